@@ design/dtr_pkg.sv @@
// Shared types and constants for the table-driven DFA recognizer.
// Holds the mode codes, the table entry and result structs, and parameter defaults.
// No dependencies.
`default_nettype none

package dtr_pkg;

	// Default sizing of the automaton.
	localparam int NUM_STATES_DEF  = 16;
	localparam int SYMBOL_BITS_DEF = 8;

	// Widths fixed by the request fields.
	localparam int STATE_W  = 4;
	localparam int SYMBOL_W = 8;
	localparam int MODE_W   = 2;
	localparam int MASK_W   = 16;

	// Depth of the result queue in front of the output port.
	localparam int OUTQ_DEPTH = 4;

	// Request mode codes.
	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SYMBOL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_END    = 2'd2;

	// One transition table entry.
	typedef struct packed {
		logic               valid;
		logic [STATE_W-1:0] next;
	} dtr_entry_t;

	localparam int ENTRY_W = $bits(dtr_entry_t);

	// One result entry.
	typedef struct packed {
		logic [STATE_W-1:0] current_state;
		logic               no_transition;
		logic               conflict;
		logic               verdict_ready;
		logic               accepted;
	} dtr_result_t;

endpackage

`default_nettype wire

@@ design/dfa_table_recognizer_top.sv @@
// Table-driven DFA recognizer: one request per unstalled cycle, a result for each.
// Each accepted request is read from the table into stage 1, where its result is
// built and pushed into the result queue that drives the output.
// Throughput: one request per cycle while in_stall is low; the path from the table
// read data back to the next table read address is the loop that sets this.
// Reset: after arst_n releases, a clearing pass writes every table entry, taking
// NUM_STATES * 2**SYMBOL_BITS writes (4096 by default); in_stall is high meanwhile.
`default_nettype none

module dfa_table_recognizer_top #(
	parameter int NUM_STATES  = dtr_pkg::NUM_STATES_DEF,
	parameter int SYMBOL_BITS = dtr_pkg::SYMBOL_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration port.
	input  wire logic                          final_mask_we,
	input  wire logic [dtr_pkg::MASK_W-1:0]    final_mask,
	// Input channel.
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [dtr_pkg::MODE_W-1:0]    mode,
	input  wire logic [dtr_pkg::STATE_W-1:0]   from_state,
	input  wire logic [dtr_pkg::STATE_W-1:0]   to_state,
	input  wire logic [dtr_pkg::SYMBOL_W-1:0]  symbol,
	// Output channel.
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [dtr_pkg::STATE_W-1:0]        current_state,
	output logic                               no_transition,
	output logic                               conflict,
	output logic                               verdict_ready,
	output logic                               accepted
);

	localparam int SIDX_W   = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int ADDR_W   = SIDX_W + SYMBOL_BITS;
	localparam int DEPTH    = NUM_STATES * (2 ** SYMBOL_BITS);
	localparam int OQ_CNT_W = $clog2(dtr_pkg::OUTQ_DEPTH + 1);

	// Control state.
	logic                          clr_busy_q;
	logic [ADDR_W-1:0]             clr_addr_q;
	logic [dtr_pkg::STATE_W-1:0]   run_q;
	logic                          dead_q;
	logic [dtr_pkg::MASK_W-1:0]    final_mask_q;
	logic                          s1_valid_q;

	// Stage 1 payload.
	logic [dtr_pkg::MODE_W-1:0]    mode_s1;
	logic [dtr_pkg::STATE_W-1:0]   to_s1;
	logic [ADDR_W-1:0]             addr_s1;
	logic                          in_range_s1;
	logic                          fwd_s1;
	dtr_pkg::dtr_entry_t           fwd_data_s1;

	// Stage 0 and table port signals.
	logic                          accept;
	logic [SYMBOL_BITS-1:0]        sym_idx;
	logic [dtr_pkg::STATE_W-1:0]   eff_state;
	logic [dtr_pkg::STATE_W-1:0]   addr_state;
	logic [ADDR_W-1:0]             rd_addr;
	logic                          in_range;
	logic [dtr_pkg::ENTRY_W-1:0]   ram_rdata;
	logic                          tbl_we;
	logic [ADDR_W-1:0]             tbl_waddr;
	dtr_pkg::dtr_entry_t           tbl_wdata;
	dtr_pkg::dtr_entry_t           add_entry;

	// Stage 1 evaluation.
	dtr_pkg::dtr_entry_t           entry;
	logic [dtr_pkg::STATE_W-1:0]   new_run;
	logic                          new_dead;
	logic                          add_we;
	dtr_pkg::dtr_result_t          result;

	logic [OQ_CNT_W-1:0]           q_count;
	dtr_pkg::dtr_result_t          q_data;

	// Input handshake: hold off while clearing or while the queue could fill.
	assign in_stall = clr_busy_q
		|| ((q_count + OQ_CNT_W'(s1_valid_q)) >= OQ_CNT_W'(dtr_pkg::OUTQ_DEPTH - 1));
	assign accept   = in_valid && !in_stall;

	// Table read address: the run state comes from the stage 1 item when there is one.
	assign sym_idx    = symbol[SYMBOL_BITS-1:0];
	assign eff_state  = s1_valid_q ? new_run : run_q;
	assign addr_state = (mode == dtr_pkg::MODE_ADD) ? from_state : eff_state;
	assign rd_addr    = {SIDX_W'(addr_state), sym_idx};
	assign in_range   = (int'(from_state) < NUM_STATES) && (int'(to_state) < NUM_STATES);

	// Table write port is shared by the clearing pass and add requests.
	assign add_entry.valid = 1'b1;
	assign add_entry.next  = to_s1;
	assign tbl_we    = clr_busy_q || add_we;
	assign tbl_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign tbl_wdata = clr_busy_q ? dtr_pkg::dtr_entry_t'('0) : add_entry;

	dtr_ram #(
		.WIDTH (dtr_pkg::ENTRY_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Stage 1: resolve the entry, update the run, and build the result.
	always_comb begin
		entry    = fwd_s1 ? fwd_data_s1 : dtr_pkg::dtr_entry_t'(ram_rdata);
		new_run  = run_q;
		new_dead = dead_q;
		add_we   = 1'b0;
		result   = '0;
		case (mode_s1)
			dtr_pkg::MODE_ADD: begin
				if (in_range_s1) begin
					if (entry.valid) begin
						result.conflict = 1'b1;
					end else begin
						add_we = s1_valid_q;
					end
				end
			end
			dtr_pkg::MODE_SYMBOL: begin
				if (!dead_q) begin
					if (entry.valid) begin
						new_run = entry.next;
					end else begin
						new_dead = 1'b1;
						new_run  = '0;
					end
				end
			end
			dtr_pkg::MODE_END: begin
				result.verdict_ready = 1'b1;
				result.accepted      = !dead_q && final_mask_q[run_q];
				new_run              = '0;
				new_dead             = 1'b0;
			end
			default: begin
			end
		endcase
		result.current_state = new_dead ? '0 : new_run;
		result.no_transition = new_dead;
	end

	// Stage 1 payload, with forwarding of a same-cycle table write.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1     <= mode;
			to_s1       <= to_state;
			addr_s1     <= rd_addr;
			in_range_s1 <= in_range;
			fwd_s1      <= add_we && (addr_s1 == rd_addr);
			fwd_data_s1 <= add_entry;
		end
	end

	// Control state and the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q   <= 1'b1;
			clr_addr_q   <= '0;
			run_q        <= '0;
			dead_q       <= 1'b0;
			final_mask_q <= '0;
			s1_valid_q   <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			if (final_mask_we) begin
				final_mask_q <= final_mask;
			end
			s1_valid_q <= accept;
			if (s1_valid_q) begin
				run_q  <= new_run;
				dead_q <= new_dead;
			end
		end
	end

	dtr_outq #(
		.DEPTH (dtr_pkg::OUTQ_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_valid_q),
		.push_data (result),
		.count     (q_count),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (q_data)
	);

	assign current_state = q_data.current_state;
	assign no_transition = q_data.no_transition;
	assign conflict      = q_data.conflict;
	assign verdict_ready = q_data.verdict_ready;
	assign accepted      = q_data.accepted;

`ifndef SYNTHESIS
	// A dead run always rests at state zero.
	a_dead_state_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dead_q |-> run_q == '0)
		else $error("dead run holds a nonzero state");

	// The clearing pass and an add request never compete for the write port.
	a_clear_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s1_valid_q && !accept)
		else $error("request in flight during table clear");

	// The clearing pass ends only after the last entry is written.
	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> $past(clr_addr_q) == ADDR_W'(DEPTH - 1))
		else $error("table clear ended early");

	// A conflict is reported only for an add request.
	a_conflict_on_add: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && result.conflict |-> mode_s1 == dtr_pkg::MODE_ADD)
		else $error("conflict flagged on a non-add request");

	// The queue always has room when stage 1 pushes.
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> q_count < OQ_CNT_W'(dtr_pkg::OUTQ_DEPTH))
		else $error("stage 1 pushed into a full result queue");
`endif

endmodule

`default_nettype wire

@@ design/dtr_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered: it appears in the cycle after a read enable.
// No dependencies.
`default_nettype none

module dtr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; read-during-write to the same address returns old data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ design/dtr_outq.sv @@
// Small result queue that decouples the table pipeline from the output port.
// Depends on dtr_pkg for the result struct.
`default_nettype none

module dtr_outq #(
	parameter int DEPTH = dtr_pkg::OUTQ_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire dtr_pkg::dtr_result_t       push_data,
	output logic [$clog2(DEPTH+1)-1:0]      count,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output dtr_pkg::dtr_result_t            out_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	dtr_pkg::dtr_result_t slot_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 pop;

	assign pop       = out_valid && !out_stall;
	assign out_valid = (count_q != '0);
	assign out_data  = slot_q[rd_ptr_q];
	assign count     = count_q;

	// Storage slots need no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	// A push without a pop never lands on a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q < CNT_W'(DEPTH))
		else $error("result queue overflow");

	// The count advances by one on a push without a pop.
	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("result queue count did not advance on push");
`endif

endmodule

`default_nettype wire
